FILE: rtl/move_to_front_partial_insert_unit_defines.svh
// Assertion macros for the move-to-front unit.
// Included by mtfpi_ctrl, the module that carries concurrent checks; no other dependencies.
`ifndef MOVE_TO_FRONT_PARTIAL_INSERT_UNIT_DEFINES_SVH
`define MOVE_TO_FRONT_PARTIAL_INSERT_UNIT_DEFINES_SVH

`ifndef SYNTH
// checked only outside reset
`define MTFPI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked during reset as well
`define MTFPI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTFPI_ASSERT(lbl, prop, msg)
`define MTFPI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/mtfpi_pkg.sv
// Shared constants and types for the move-to-front unit.
// No dependencies.
package mtfpi_pkg;

    localparam int MAX_SYMBOLS = 256;
    localparam int SYM_W       = $clog2(MAX_SYMBOLS);
    localparam int SIZE_W      = SYM_W + 1;
    localparam int GROUP_LEN   = 16;
    localparam int GROUPS      = MAX_SYMBOLS / GROUP_LEN;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = SIZE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_POSITION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INSERT_POSITION = 2'd2;

    localparam logic [SIZE_W-1:0] ALPHABET_SIZE_RST   = 9'd256;
    localparam logic [SIZE_W-1:0] ESCAPE_POSITION_RST = 9'd123;
    localparam logic [SYM_W-1:0]  INSERT_POSITION_RST = 8'd96;
    localparam logic [SIZE_W-1:0] MIN_SIZE            = 9'd2;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // command broadcast along the cell chain
    typedef struct packed {
        logic             init;
        logic             match;
        logic             seek;
        logic             by_index;
        logic [SYM_W-1:0] key;
        logic             move;
        logic             shift_up;
        logic [SYM_W-1:0] lo;
        logic [SYM_W-1:0] hi;
        logic [SYM_W-1:0] fill;
    } cell_cmd_t;

    // result of the match search
    typedef struct packed {
        logic [SYM_W-1:0] pos;
        logic [SYM_W-1:0] val;
    } found_t;

endpackage

FILE: rtl/move_to_front_partial_insert_unit.sv
// Move-to-front unit with partial reinsertion of escaped symbols: a chain of
// list cells, the match gather tree and the sequencer. Depends on mtfpi_pkg.
//
//  channel | handshake          | word
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | operation, symbol_in, position_in, escape_run
//  out     | out_valid/out_stall| symbol_out, position_out, escaped, error
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An item passes through capture, cell compare, gather, plan and shift of the
// cell chain in that order; the result word is loaded with the shift step.
// The next word is taken while the result word waits in the output register.
// Reset and every accepted write to a known register load identity order into the cells;
// an offered register write holds off the input word in that cycle.
// A stalled output holds the shift step until the output register frees.
module move_to_front_partial_insert_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [mtfpi_pkg::SYM_W-1:0]      symbol_in,
    input  logic [mtfpi_pkg::SYM_W-1:0]      position_in,
    input  logic                             escape_run,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mtfpi_pkg::SYM_W-1:0]      symbol_out,
    output logic [mtfpi_pkg::SYM_W-1:0]      position_out,
    output logic                             escaped,
    output logic                             error,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mtfpi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mtfpi_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mtfpi_pkg::*;

    cell_cmd_t        cmd;
    found_t           found;
    logic [MAX_SYMBOLS-1:0] hits;
    logic [SYM_W-1:0] vals [MAX_SYMBOLS];

    genvar i;
    generate
        for (i = 0; i < MAX_SYMBOLS; i++)
        begin : g_cell
            logic [SYM_W-1:0] prev_v;
            logic [SYM_W-1:0] next_v;
            // end cells never take from beyond the chain
            if (i == 0)
            begin : g_first
                assign prev_v = '0;
            end
            else
            begin : g_prev
                assign prev_v = vals[i-1];
            end
            if (i == MAX_SYMBOLS - 1)
            begin : g_last
                assign next_v = '0;
            end
            else
            begin : g_next
                assign next_v = vals[i+1];
            end

            mtfpi_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .index    (SYM_W'(i)),
                .cmd      (cmd),
                .prev_val (prev_v),
                .next_val (next_v),
                .val      (vals[i]),
                .hit      (hits[i])
            );
        end
    endgenerate

    mtfpi_gather u_gather (
        .clk   (clk),
        .hits  (hits),
        .vals  (vals),
        .found (found)
    );

    mtfpi_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .symbol_in    (symbol_in),
        .position_in  (position_in),
        .escape_run   (escape_run),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .symbol_out   (symbol_out),
        .position_out (position_out),
        .escaped      (escaped),
        .error        (error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .found        (found),
        .cmd          (cmd)
    );

endmodule

FILE: rtl/mtfpi_cell.sv
// One list entry of the move-to-front chain: holds a symbol, flags a match,
// and shifts from either neighbour on a move. Depends on mtfpi_pkg.
module mtfpi_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [mtfpi_pkg::SYM_W-1:0] index,
    input  mtfpi_pkg::cell_cmd_t      cmd,
    input  logic [mtfpi_pkg::SYM_W-1:0] prev_val,
    input  logic [mtfpi_pkg::SYM_W-1:0] next_val,
    output logic [mtfpi_pkg::SYM_W-1:0] val,
    output logic                      hit
);
    import mtfpi_pkg::*;

    logic [SYM_W-1:0] val_reg;
    logic [SYM_W-1:0] val_next;
    logic             hit_reg;
    logic             hit_next;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.init)
        begin
            val_next = index;
        end
        else if (cmd.move)
        begin
            if (cmd.shift_up)
            begin
                if (index == cmd.lo)
                    val_next = cmd.fill;
                else if (index > cmd.lo && index <= cmd.hi)
                    val_next = prev_val;
            end
            else
            begin
                if (index == cmd.hi)
                    val_next = cmd.fill;
                else if (index >= cmd.lo && index < cmd.hi)
                    val_next = next_val;
            end
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (cmd.match)
            hit_next = cmd.seek && (cmd.by_index ? (index == cmd.key) : (val_reg == cmd.key));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= index;
            hit_reg <= 1'b0;
        end
        else
        begin
            val_reg <= val_next;
            hit_reg <= hit_next;
        end
    end

    assign val = val_reg;
    assign hit = hit_reg;

endmodule

FILE: rtl/mtfpi_gather.sv
// Two-level OR tree that turns the one-hot match flags of the chain into
// the matching position and symbol. Depends on mtfpi_pkg.
module mtfpi_gather (
    input  logic                        clk,
    input  logic [mtfpi_pkg::MAX_SYMBOLS-1:0] hits,
    input  logic [mtfpi_pkg::SYM_W-1:0]       vals [mtfpi_pkg::MAX_SYMBOLS],
    output mtfpi_pkg::found_t           found
);
    import mtfpi_pkg::*;

    logic [SYM_W-1:0] grp_pos_reg  [GROUPS];
    logic [SYM_W-1:0] grp_val_reg  [GROUPS];
    logic [SYM_W-1:0] grp_pos_next [GROUPS];
    logic [SYM_W-1:0] grp_val_next [GROUPS];

    // at most one flag is set, so a plain OR selects it
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_pos_next[g] = '0;
            grp_val_next[g] = '0;
            for (int j = 0; j < GROUP_LEN; j++)
            begin
                if (hits[g*GROUP_LEN + j])
                begin
                    grp_pos_next[g] = grp_pos_next[g] | SYM_W'(g*GROUP_LEN + j);
                    grp_val_next[g] = grp_val_next[g] | vals[g*GROUP_LEN + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_pos_reg <= grp_pos_next;
        grp_val_reg <= grp_val_next;
    end

    always_comb
    begin
        found = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            found.pos = found.pos | grp_pos_reg[g];
            found.val = found.val | grp_val_reg[g];
        end
    end

endmodule

FILE: rtl/mtfpi_ctrl.sv
// Sequencer of the move-to-front unit: configuration registers, item capture,
// move planning and the output word register. Depends on mtfpi_pkg and the
// assertion macros header.
`include "move_to_front_partial_insert_unit_defines.svh"

module mtfpi_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [mtfpi_pkg::SYM_W-1:0]      symbol_in,
    input  logic [mtfpi_pkg::SYM_W-1:0]      position_in,
    input  logic                             escape_run,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mtfpi_pkg::SYM_W-1:0]      symbol_out,
    output logic [mtfpi_pkg::SYM_W-1:0]      position_out,
    output logic                             escaped,
    output logic                             error,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mtfpi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mtfpi_pkg::CFG_DATA_W-1:0] cfg_data,
    input  mtfpi_pkg::found_t                found,
    output mtfpi_pkg::cell_cmd_t             cmd
);
    import mtfpi_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MATCH  = 5'b00010,
        ST_GATHER = 5'b00100,
        ST_PLAN   = 5'b01000,
        ST_MOVE   = 5'b10000
    } state_t;

    typedef struct packed {
        logic             move;
        logic             shift_up;
        logic [SYM_W-1:0] lo;
        logic [SYM_W-1:0] hi;
        logic [SYM_W-1:0] fill;
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] pos;
        logic             esc;
        logic             err;
    } plan_t;

    state_t           state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, esc_pos_reg;
    logic [SYM_W-1:0]  ins_pos_reg;
    logic [SIZE_W-1:0] size_eff;
    logic [SYM_W-1:0]  size_m1;

    logic             op_reg;
    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] pos_reg;
    logic             aesc_reg;
    logic             err_reg;
    logic             err_next;

    plan_t            plan_reg, plan_next;
    logic [SYM_W-1:0] target;
    logic [SYM_W-1:0] target_m1;
    logic [SYM_W-1:0] last_pos;

    logic             out_valid_reg;
    logic [SYM_W-1:0] sym_out_reg, pos_out_reg;
    logic             esc_out_reg, err_out_reg;

    logic             in_take;
    logic             cfg_take;
    logic             cfg_hit;
    logic             out_free;
    logic             out_load;

    assign size_eff = (size_reg < MIN_SIZE) ? MIN_SIZE :
                      (size_reg > SIZE_W'(MAX_SYMBOLS)) ? SIZE_W'(MAX_SYMBOLS) : size_reg;
    assign size_m1  = SYM_W'(size_eff - SIZE_W'(1));

    // hold the input while a register write is offered
    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_take && (cfg_index == CFG_ALPHABET_SIZE ||
                                    cfg_index == CFG_ESCAPE_POSITION ||
                                    cfg_index == CFG_INSERT_POSITION);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_MOVE) && out_free;

    assign err_next = (operation == OP_DECODE) ? ({1'b0, position_in} >= size_eff)
                                               : ({1'b0, symbol_in} >= size_eff);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_take) state_next = ST_MATCH;
            ST_MATCH:  state_next = ST_GATHER;
            ST_GATHER: state_next = ST_PLAN;
            ST_PLAN:   state_next = ST_MOVE;
            ST_MOVE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // work out where the symbol goes and which span of cells shifts
    always_comb
    begin
        plan_next.esc = !err_reg && ((op_reg == OP_DECODE) ? aesc_reg
                                     : ({1'b0, found.pos} >= esc_pos_reg));
        target    = plan_next.esc ? ins_pos_reg : '0;
        target_m1 = target - SYM_W'(1);
        last_pos  = (target_m1 > size_m1) ? size_m1 : target_m1;

        plan_next.move     = 1'b0;
        plan_next.shift_up = 1'b0;
        plan_next.lo       = found.pos;
        plan_next.hi       = found.pos;
        plan_next.fill     = found.val;
        plan_next.err      = err_reg;
        if (!err_reg)
        begin
            if (target < found.pos)
            begin
                plan_next.move     = 1'b1;
                plan_next.shift_up = 1'b1;
                plan_next.lo       = target;
                plan_next.hi       = found.pos;
            end
            else if (target > found.pos && last_pos > found.pos)
            begin
                plan_next.move = 1'b1;
                plan_next.lo   = found.pos;
                plan_next.hi   = last_pos;
            end
        end

        if (op_reg == OP_DECODE)
        begin
            plan_next.sym = err_reg ? '0 : found.val;
            plan_next.pos = pos_reg;
        end
        else
        begin
            plan_next.sym = sym_reg;
            plan_next.pos = err_reg ? '0 : found.pos;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.init     = cfg_hit;
        cmd.match    = (state_reg == ST_MATCH);
        cmd.seek     = !err_reg;
        cmd.by_index = (op_reg == OP_DECODE);
        cmd.key      = (op_reg == OP_DECODE) ? pos_reg : sym_reg;
        cmd.move     = out_load && plan_reg.move;
        cmd.shift_up = plan_reg.shift_up;
        cmd.lo       = plan_reg.lo;
        cmd.hi       = plan_reg.hi;
        cmd.fill     = plan_reg.fill;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= ALPHABET_SIZE_RST;
            esc_pos_reg   <= ESCAPE_POSITION_RST;
            ins_pos_reg   <= INSERT_POSITION_RST;
            out_valid_reg <= 1'b0;
            plan_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_take)
            begin
                unique case (cfg_index)
                    CFG_ALPHABET_SIZE:   size_reg    <= cfg_data;
                    CFG_ESCAPE_POSITION: esc_pos_reg <= cfg_data;
                    CFG_INSERT_POSITION: ins_pos_reg <= cfg_data[SYM_W-1:0];
                    default:             ;
                endcase
            end
            if (state_reg == ST_PLAN)
                plan_reg <= plan_next;
            // drop the word once taken, hold it while stalled
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= operation;
            sym_reg  <= symbol_in;
            pos_reg  <= position_in;
            aesc_reg <= escape_run;
            err_reg  <= err_next;
        end
        if (out_load)
        begin
            sym_out_reg <= plan_reg.sym;
            pos_out_reg <= plan_reg.pos;
            esc_out_reg <= plan_reg.esc;
            err_out_reg <= plan_reg.err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign symbol_out   = sym_out_reg;
    assign position_out = pos_out_reg;
    assign escaped      = esc_out_reg;
    assign error        = err_out_reg;

    `MTFPI_ASSERT(a_span_ordered, plan_reg.move |-> (plan_reg.lo < plan_reg.hi), "move span reversed")
    `MTFPI_ASSERT(a_span_in_list, (state_reg == ST_MOVE && plan_reg.move) |-> ({1'b0, plan_reg.hi} < size_eff), "move past list end")
    `MTFPI_ASSERT(a_error_no_move, plan_reg.err |-> !plan_reg.move, "move planned for a bad item")
    `MTFPI_ASSERT(a_load_shows, out_load |=> out_valid_reg, "result word lost")
    `MTFPI_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |-> !cmd.move, "move during reset")

endmodule
